// File: rtl/core/bpa_pkg.sv
package bpa_pkg;

  localparam int PAGE_COUNT  = 4096;
  localparam int ORDER_COUNT = 11;
  localparam int PAGE_W      = $clog2(PAGE_COUNT);
  localparam int LINK_W      = PAGE_W + 1;
  localparam int ORD_W       = $clog2(ORDER_COUNT);
  localparam int CNT_W       = PAGE_W + 1;
  localparam int FILL_W      = CNT_W + 7;

  localparam logic [LINK_W-1:0] NO_PAGE  = LINK_W'(PAGE_COUNT);
  localparam logic [6:0]        FILL_NUM = 7'd99;
  localparam logic [6:0]        FILL_DEN = 7'd100;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_SEED  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_ROOM   = 3'd3,
    ST_RANGE     = 3'd4,
    ST_NOT_ALLOC = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] request_pages;
    logic [11:0] page_number;
  } bpa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] block_page;
    logic [3:0]  block_order;
  } bpa_out_t;

  typedef struct packed {
    logic             taken;
    logic [ORD_W-1:0] order;
  } info_t;

  typedef struct packed {
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } link_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [PAGE_W-1:0] addr;
    info_t             wdata;
  } info_req_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [PAGE_W-1:0] addr;
    link_t             wdata;
  } link_req_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DONE,
    A_CHECK,
    A_SPLIT,
    A_SPLIT2,
    A_QORD_RD,
    A_QORD_WR,
    A_BORD_RD,
    A_BORD_WR,
    A_TAKE_RD,
    A_TAKE_WR,
    F_CHK,
    F_TK_RD,
    F_TK_WR,
    F_LOOP,
    F_LCHK,
    F_UQ,
    F_MRG,
    F_MWR,
    P_A,
    P_B,
    P_C,
    U_A,
    U_B,
    U_C,
    U_D,
    U_E,
    U_F
  } state_t;

endpackage

// File: rtl/core/buddy_page_allocator.sv
// Buddy page allocator over 4096 pages with free lists for orders 0 to 10.
// Input channel in_valid/in_ready/in_data carries one request transaction:
// allocate, free block or seed page. Output channel out_valid/out_ready/
// out_data returns exactly one result transaction per request, in order.
// A request is taken only while the sequencer is idle; it then runs as a
// sequence of single-port accesses to the page-info and link memories,
// one access to each per cycle, with registered read data.
// A request checked at intake (zero or too large size, undefined op) goes
// straight from idle to the result state; others run list pushes, unlinks
// and split or merge steps, and the next request is taken in the cycle
// after the result leaves the sequencer.
// After reset the page-info memory is swept once, page by page, before the
// first request is taken.
// The result sits in an output register; a new request is taken while it
// waits, and a further result is held inside until out_ready frees the
// register.
module buddy_page_allocator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpa_pkg::bpa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bpa_pkg::bpa_out_t out_data
);
  import bpa_pkg::*;

  info_req_t info_req;
  info_t     info_rd;
  link_req_t link_req;
  link_t     link_rd;
  logic      res_valid, res_ready;
  bpa_out_t  res_data;

  bpa_info_ram u_info (
    .clk (clk),
    .req (info_req),
    .rd  (info_rd)
  );

  bpa_link_ram u_link (
    .clk (clk),
    .req (link_req),
    .rd  (link_rd)
  );

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .info_req  (info_req),
    .info_rd   (info_rd),
    .link_req  (link_req),
    .link_rd   (link_rd)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

// File: rtl/core/bpa_info_ram.sv
module bpa_info_ram (
  input  logic               clk,
  input  bpa_pkg::info_req_t req,
  output bpa_pkg::info_t     rd
);
  import bpa_pkg::*;

  info_t mem [PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd <= mem[req.addr];
    end
  end

endmodule

// File: rtl/core/bpa_link_ram.sv
module bpa_link_ram (
  input  logic               clk,
  input  bpa_pkg::link_req_t req,
  output bpa_pkg::link_t     rd
);
  import bpa_pkg::*;

  link_t mem [PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd <= mem[req.addr];
    end
  end

endmodule

// File: rtl/core/bpa_ctrl.sv
module bpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpa_pkg::bpa_in_t   in_data,
  output logic               res_valid,
  input  logic               res_ready,
  output bpa_pkg::bpa_out_t  res_data,
  output bpa_pkg::info_req_t info_req,
  input  bpa_pkg::info_t     info_rd,
  output bpa_pkg::link_req_t link_req,
  input  bpa_pkg::link_t     link_rd
);
  import bpa_pkg::*;

  localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(ORDER_COUNT - 1);

  state_t              state, state_next, ret;
  logic [PAGE_W-1:0]   clr_cnt;
  logic [LINK_W-1:0]   list_first [ORDER_COUNT];
  logic [CNT_W-1:0]    used_pages, total_pages;
  logic [ORD_W-1:0]    want, ord, sub_ord;
  logic [PAGE_W-1:0]   cur_p, cur_q, sub_p;
  logic [LINK_W-1:0]   sub_n, sub_pr;
  logic                is_seed;
  bpa_out_t            res;

  logic [4:0]          want_c;
  logic [15:0]         req_m1;
  logic                bad_req;
  logic                found;
  logic [ORD_W-1:0]    found_ord;
  logic                fill_hit;
  logic [PAGE_W-1:0]   ord_bit, ord_bit_dn, q_c, p_mrg;
  logic [ORD_W-1:0]    ord0;
  logic [CNT_W-1:0]    free_sz;
  logic [CNT_W:0]      used_sum;
  logic                merge_stop;

  // ceiling log2 of the request
  always_comb begin
    req_m1 = in_data.request_pages - 16'd1;
    want_c = '0;
    for (int i = 0; i < 16; i++) begin
      if (req_m1[i]) want_c = 5'(i + 1);
    end
    bad_req = (in_data.request_pages == 16'd0) || (want_c >= 5'(ORDER_COUNT));
  end

  always_comb begin
    found     = 1'b0;
    found_ord = '0;
    for (int i = ORDER_COUNT - 1; i >= 0; i--) begin
      if (ORD_W'(i) >= want && list_first[i] != NO_PAGE) begin
        found     = 1'b1;
        found_ord = ORD_W'(i);
      end
    end
    fill_hit = (FILL_W'(used_pages) * FILL_W'(FILL_DEN)) >=
               (FILL_W'(total_pages) * FILL_W'(FILL_NUM));
  end

  always_comb begin
    ord_bit    = PAGE_W'(1) << ord;
    ord_bit_dn = PAGE_W'(1) << (ord - ORD_W'(1));
    q_c        = cur_p ^ ord_bit;
    p_mrg      = cur_p & ~ord_bit;
    ord0       = (info_rd.order >= ORD_W'(ORDER_COUNT)) ? '0 : info_rd.order;
    free_sz    = CNT_W'(1) << ord0;
    used_sum   = {1'b0, used_pages} + ((CNT_W + 1)'(1) << want);
    merge_stop = info_rd.taken || (info_rd.order != ord);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(in_data.func))
            FN_ALLOC:        state_next = bad_req ? S_DONE : A_CHECK;
            FN_FREE, FN_SEED: state_next = F_CHK;
            FN_NONE:         state_next = S_DONE;
          endcase
        end
      end
      S_DONE:    if (res_ready) state_next = S_IDLE;
      A_CHECK:   state_next = (!found || fill_hit) ? S_DONE : A_SPLIT;
      A_SPLIT:   state_next = U_A;
      A_SPLIT2:  state_next = P_A;
      A_QORD_RD: state_next = A_QORD_WR;
      A_QORD_WR: state_next = P_A;
      A_BORD_RD: state_next = A_BORD_WR;
      A_BORD_WR: state_next = A_SPLIT;
      A_TAKE_RD: state_next = A_TAKE_WR;
      A_TAKE_WR: state_next = S_DONE;
      F_CHK:     state_next = info_rd.taken ? P_A : S_DONE;
      F_TK_RD:   state_next = F_TK_WR;
      F_TK_WR:   state_next = F_LOOP;
      F_LOOP:    state_next = (ord >= TOP_ORD) ? S_DONE : F_LCHK;
      F_LCHK:    state_next = merge_stop ? S_DONE : U_A;
      F_UQ:      state_next = U_A;
      F_MRG:     state_next = F_MWR;
      F_MWR:     state_next = P_A;
      P_A:       state_next = (list_first[sub_ord] != NO_PAGE) ? P_B : ret;
      P_B:       state_next = P_C;
      P_C:       state_next = ret;
      U_A:       state_next = U_B;
      U_B:       state_next = (link_rd.next < NO_PAGE) ? U_C : U_D;
      U_C:       state_next = U_D;
      U_D:       state_next = (sub_pr < NO_PAGE) ? U_E : U_F;
      U_E:       state_next = U_F;
      U_F:       state_next = ret;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    info_req = '0;
    link_req = '0;
    unique case (state)
      S_CLEAR: begin
        info_req.we    = 1'b1;
        info_req.addr  = clr_cnt;
        info_req.wdata = '{taken: 1'b1, order: '0};
      end
      S_IDLE: begin
        info_req.re   = in_valid && (in_data.func == FN_FREE || in_data.func == FN_SEED);
        info_req.addr = in_data.page_number;
      end
      A_QORD_RD: begin
        info_req.re   = 1'b1;
        info_req.addr = cur_q;
      end
      A_QORD_WR: begin
        info_req.we    = 1'b1;
        info_req.addr  = cur_q;
        info_req.wdata = '{taken: info_rd.taken, order: ord};
      end
      A_BORD_RD, A_TAKE_RD, F_TK_RD: begin
        info_req.re   = 1'b1;
        info_req.addr = cur_p;
      end
      A_BORD_WR, F_MWR: begin
        info_req.we    = 1'b1;
        info_req.addr  = cur_p;
        info_req.wdata = '{taken: info_rd.taken, order: ord};
      end
      A_TAKE_WR: begin
        info_req.we    = 1'b1;
        info_req.addr  = cur_p;
        info_req.wdata = '{taken: 1'b1, order: info_rd.order};
      end
      F_TK_WR: begin
        info_req.we    = 1'b1;
        info_req.addr  = cur_p;
        info_req.wdata = '{taken: 1'b0, order: info_rd.order};
      end
      F_LOOP: begin
        info_req.re   = ord < TOP_ORD;
        info_req.addr = q_c;
      end
      F_MRG: begin
        info_req.re   = 1'b1;
        info_req.addr = p_mrg;
      end
      P_A: begin
        link_req.we    = 1'b1;
        link_req.addr  = sub_p;
        link_req.wdata = '{next: list_first[sub_ord], prev: NO_PAGE};
      end
      P_B: begin
        link_req.re   = 1'b1;
        link_req.addr = sub_n[PAGE_W-1:0];
      end
      P_C: begin
        link_req.we    = 1'b1;
        link_req.addr  = sub_n[PAGE_W-1:0];
        link_req.wdata = '{next: link_rd.next, prev: {1'b0, sub_p}};
      end
      U_A: begin
        link_req.re   = 1'b1;
        link_req.addr = sub_p;
      end
      U_B: begin
        link_req.re   = link_rd.next < NO_PAGE;
        link_req.addr = link_rd.next[PAGE_W-1:0];
      end
      U_C: begin
        link_req.we    = 1'b1;
        link_req.addr  = sub_n[PAGE_W-1:0];
        link_req.wdata = '{next: link_rd.next, prev: sub_pr};
      end
      U_D: begin
        link_req.re   = sub_pr < NO_PAGE;
        link_req.addr = sub_pr[PAGE_W-1:0];
      end
      U_E: begin
        link_req.we    = 1'b1;
        link_req.addr  = sub_pr[PAGE_W-1:0];
        link_req.wdata = '{next: sub_n, prev: link_rd.prev};
      end
      U_F: begin
        link_req.we    = 1'b1;
        link_req.addr  = sub_p;
        link_req.wdata = '{next: {1'b0, sub_p}, prev: {1'b0, sub_p}};
      end
      default: begin
        info_req = '0;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      used_pages  <= '0;
      total_pages <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) list_first[i] <= NO_PAGE;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_cnt <= clr_cnt + PAGE_W'(1);
        S_IDLE: begin
          res     <= '0;
          cur_p   <= in_data.page_number;
          is_seed <= (in_data.func == FN_SEED);
          want    <= want_c[ORD_W-1:0];
          if (in_data.func == FN_ALLOC) begin
            if (in_data.request_pages == 16'd0) begin
              res.status <= ST_ZERO;
            end else if (want_c >= 5'(ORDER_COUNT)) begin
              res.status <= ST_TOO_LARGE;
            end
          end
        end
        A_CHECK: begin
          ord <= found_ord;
          if (!found || fill_hit) res.status <= ST_NO_ROOM;
        end
        A_SPLIT: begin
          cur_p   <= list_first[ord][PAGE_W-1:0];
          sub_ord <= ord;
          sub_p   <= list_first[ord][PAGE_W-1:0];
          ret     <= (ord > want) ? A_SPLIT2 : A_TAKE_RD;
        end
        A_SPLIT2: begin
          ord     <= ord - ORD_W'(1);
          cur_q   <= cur_p ^ ord_bit_dn;
          sub_ord <= ord - ORD_W'(1);
          sub_p   <= cur_p ^ ord_bit_dn;
          ret     <= A_QORD_RD;
        end
        A_QORD_WR: begin
          sub_ord <= ord;
          sub_p   <= cur_p;
          ret     <= A_BORD_RD;
        end
        A_TAKE_WR: begin
          used_pages <= (used_sum > (CNT_W + 1)'(PAGE_COUNT)) ?
                        CNT_W'(PAGE_COUNT) : used_sum[CNT_W-1:0];
          res.status      <= ST_OK;
          res.block_page  <= cur_p;
          res.block_order <= want;
        end
        F_CHK: begin
          if (!info_rd.taken) begin
            res.status <= ST_NOT_ALLOC;
          end else begin
            ord     <= ord0;
            sub_ord <= ord0;
            sub_p   <= cur_p;
            ret     <= F_TK_RD;
            if (!is_seed) begin
              used_pages <= (used_pages > free_sz) ? used_pages - free_sz : '0;
            end else if (total_pages < CNT_W'(PAGE_COUNT)) begin
              total_pages <= total_pages + CNT_W'(1);
            end
          end
        end
        F_LOOP: begin
          cur_q           <= q_c;
          res.block_page  <= cur_p;
          res.block_order <= ord;
        end
        F_LCHK: begin
          sub_ord <= ord;
          sub_p   <= cur_p;
          ret     <= F_UQ;
        end
        F_UQ: begin
          sub_ord <= ord;
          sub_p   <= cur_q;
          ret     <= F_MRG;
        end
        F_MRG: begin
          cur_p <= p_mrg;
          ord   <= ord + ORD_W'(1);
        end
        F_MWR: begin
          sub_ord <= ord;
          sub_p   <= cur_p;
          ret     <= F_LOOP;
        end
        P_A: begin
          sub_n               <= list_first[sub_ord];
          list_first[sub_ord] <= {1'b0, sub_p};
        end
        U_B: begin
          sub_n  <= link_rd.next;
          sub_pr <= link_rd.prev;
        end
        U_D: begin
          if (sub_pr >= NO_PAGE) list_first[sub_ord] <= sub_n;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: tb/sv/buddy_page_allocator_checker.sv
module buddy_page_allocator_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  bpa_pkg::bpa_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  bpa_pkg::bpa_out_t out_data,
  output int                errors,
  output int                outstanding
);
  import bpa_pkg::*;

  localparam int unsigned NONE = PAGE_COUNT;

  logic [3:0]  blk_ord [PAGE_COUNT];
  bit          blk_taken [PAGE_COUNT];
  int unsigned nxt [PAGE_COUNT];
  int unsigned prv [PAGE_COUNT];
  int unsigned head [ORDER_COUNT];
  int unsigned pages_used;
  int unsigned pages_total;
  bpa_out_t    awaited_results[$];

  function automatic void list_add(int unsigned o, int unsigned p);
    int unsigned h;
    if (o >= ORDER_COUNT || p >= NONE) return;
    h = head[o];
    nxt[p] = h;
    prv[p] = NONE;
    if (h < NONE) prv[h] = p;
    head[o] = p;
  endfunction

  function automatic void list_del(int unsigned o, int unsigned p);
    int unsigned n, b;
    if (o >= ORDER_COUNT || p >= NONE) return;
    n = nxt[p];
    b = prv[p];
    if (n < NONE) prv[n] = b;
    if (b < NONE) nxt[b] = n;
    else head[o] = n;
    nxt[p] = p;
    prv[p] = p;
  endfunction

  function automatic int unsigned give_back(int unsigned p, output int unsigned o);
    int unsigned q;
    o = blk_ord[p];
    if (o >= ORDER_COUNT) o = 0;
    list_add(o, p);
    blk_taken[p] = 0;
    while (o + 1 < ORDER_COUNT) begin
      q = p ^ (1 << o);
      if (q >= NONE || blk_taken[q] || blk_ord[q] != o) break;
      list_del(o, p);
      list_del(o, q);
      p = p & ~(1 << o);
      o++;
      blk_ord[p] = 4'(o);
      list_add(o, p);
    end
    return p;
  endfunction

  function automatic bpa_out_t serve_request(bpa_in_t r);
    bpa_out_t    res;
    int unsigned want, o, b, q, sz, o0, fo;
    res = '0;
    if (r.func == FN_ALLOC) begin
      want = 0;
      while (want < 31 && (32'd1 << want) < r.request_pages) want++;
      if (r.request_pages == 0) begin
        res.status = ST_ZERO;
      end else if (want >= ORDER_COUNT) begin
        res.status = ST_TOO_LARGE;
      end else begin
        o = want;
        while (o + 1 < ORDER_COUNT && head[o] >= NONE) o++;
        if (head[o] >= NONE ||
            longint'(pages_used) * 100 >= longint'(pages_total) * 99) begin
          res.status = ST_NO_ROOM;
        end else begin
          while (o > want) begin
            b = head[o];
            list_del(o, b);
            o--;
            q = b ^ (1 << o);
            if (q < NONE) begin
              list_add(o, q);
              blk_ord[q] = 4'(o);
            end
            list_add(o, b);
            blk_ord[b] = 4'(o);
          end
          b = head[o];
          list_del(o, b);
          blk_taken[b] = 1;
          pages_used += 1 << want;
          if (pages_used > PAGE_COUNT) pages_used = PAGE_COUNT;
          res.status = ST_OK;
          res.block_page = 12'(b);
          res.block_order = 4'(want);
        end
      end
    end else if (r.func == FN_FREE || r.func == FN_SEED) begin
      if (!blk_taken[r.page_number]) begin
        res.status = ST_NOT_ALLOC;
      end else begin
        o0 = blk_ord[r.page_number];
        if (o0 >= ORDER_COUNT) o0 = 0;
        if (r.func == FN_FREE) begin
          sz = 1 << o0;
          pages_used = (pages_used > sz) ? pages_used - sz : 0;
        end else if (pages_total < PAGE_COUNT) begin
          pages_total++;
        end
        res.status = ST_OK;
        res.block_page = 12'(give_back(r.page_number, fo));
        res.block_order = 4'(fo);
      end
    end
    return res;
  endfunction

  assign outstanding = awaited_results.size();

  always @(posedge clk) begin
    bpa_out_t want_res;
    if (rst) begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
        blk_ord[i] = 0;
        blk_taken[i] = 1;
        nxt[i] = 0;
        prv[i] = 0;
      end
      for (int i = 0; i < ORDER_COUNT; i++) head[i] = NONE;
      pages_used = 0;
      pages_total = 0;
      awaited_results.delete();
      errors <= 0;
    end else begin
      if (in_valid && in_ready) awaited_results.push_back(serve_request(in_data));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (errors < 10) $display("unexpected result transaction %p", out_data);
          errors <= errors + 1;
        end else begin
          want_res = awaited_results.pop_front();
          if (want_res.status !== out_data.status ||
              want_res.block_page !== out_data.block_page ||
              want_res.block_order !== out_data.block_order) begin
            if (errors < 10)
              $display("mismatch: exp status %0d page %0d order %0d, got %0d %0d %0d",
                       want_res.status, want_res.block_page, want_res.block_order,
                       out_data.status, out_data.block_page, out_data.block_order);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/buddy_page_allocator_tb.sv
module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;

  logic     clk = 0;
  logic     rst = 1;
  logic     in_valid = 0;
  logic     in_ready;
  bpa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 0;
  bpa_out_t out_data;
  int       errors;
  int       outstanding;

  bit          steady = 0;
  bit          hold_req = 0;
  bit          held = 0;
  int          idle_count = 0;
  int          n_alloc = 0, n_free = 0, n_seed = 0, n_other = 0;
  logic [1:0]  issued_funcs[$];
  logic [11:0] live_blocks[$];

  always #5 clk = ~clk;

  buddy_page_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  buddy_page_allocator_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .outstanding(outstanding)
  );

  // track granted blocks so that frees mostly hit live allocations
  always @(posedge clk) begin
    logic [1:0] f;
    if (!rst) begin
      if (in_valid && in_ready) issued_funcs.push_back(in_data.func);
      if (out_valid && out_ready && issued_funcs.size() > 0) begin
        f = issued_funcs.pop_front();
        if (f == FN_ALLOC && out_data.status == ST_OK) live_blocks.push_back(out_data.block_page);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic send(logic [1:0] f, logic [15:0] req, logic [11:0] pg);
    if (!steady && $urandom_range(99) < 18) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{func: f, request_pages: req, page_number: pg};
    do @(posedge clk); while (!in_ready);
    case (f)
      FN_ALLOC: n_alloc++;
      FN_FREE:  n_free++;
      FN_SEED:  n_seed++;
      default:  n_other++;
    endcase
  endtask

  task automatic random_request();
    int roll, k;
    roll = $urandom_range(99);
    if (roll < 45) begin
      send(FN_ALLOC, 16'($urandom_range(1, 1 << $urandom_range(0, 6))), '0);
    end else if (roll < 80 && live_blocks.size() > 0) begin
      k = $urandom_range(live_blocks.size() - 1);
      send(FN_FREE, 16'($urandom), live_blocks[k]);
      live_blocks.delete(k);
    end else if (roll < 86) begin
      send(FN_SEED, 16'($urandom), 12'($urandom));
    end else if (roll < 92) begin
      send(FN_ALLOC, 16'($urandom), 12'($urandom));
    end else if (roll < 97) begin
      send(FN_FREE, 16'($urandom), 12'($urandom));
    end else begin
      send(FN_NONE, 16'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;

    send(FN_ALLOC, 16'd1, 12'd0);
    send(FN_ALLOC, 16'd0, 12'hfff);
    send(FN_ALLOC, 16'd2048, 12'd0);
    send(FN_ALLOC, 16'hffff, 12'd0);
    send(FN_NONE, 16'hffff, 12'hfff);
    send(FN_FREE, 16'd0, 12'd0);
    send(FN_FREE, 16'd0, 12'd0);
    send(FN_SEED, 16'd0, 12'd0);
    send(FN_SEED, 16'd0, 12'hfff);
    send(FN_SEED, 16'd0, 12'hffe);
    send(FN_SEED, 16'd0, 12'hffe);
    send(FN_ALLOC, 16'd1024, 12'd0);
    send(FN_ALLOC, 16'd1025, 12'd0);
    send(FN_ALLOC, 16'd1, 12'd0);
    send(FN_FREE, 16'd0, 12'hfff);
    send(FN_FREE, 16'd0, 12'hffe);

    // populate the store: 512 pages merging up to order 9 blocks
    for (int p = 0; p < 512; p++) send(FN_SEED, 16'd0, 12'(p));
    send(FN_ALLOC, 16'd1024, 12'd0);
    send(FN_ALLOC, 16'd512, 12'd0);
    send(FN_FREE, 16'd0, 12'd0);
    send(FN_ALLOC, 16'd3, 12'd0);

    hold_req = 1;
    for (int i = 0; i < 720; i++) begin
      steady = (i >= 250 && i < 450);
      random_request();
    end
    steady = 0;
    in_valid <= 0;

    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("%0d requests: %0d allocate, %0d free, %0d seed, %0d undefined op",
             n_alloc + n_free + n_seed + n_other, n_alloc, n_free, n_seed, n_other);
    $display("random gaps on both sides, one long output stall of %0d cycles", HOLD_CYCLES);
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
